@@ src/dhfk_pkg.sv @@
// constants and types for the seven-joint forward kinematics pipeline
`default_nettype none
package dhfk_pkg;

  localparam int JOINT_COUNT   = 7;
  localparam int ROT_FRAC_BITS = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam int CORDIC_FRAC   = 30;

  localparam int ANG_W      = 16;
  localparam int CFG_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CX_W       = 34;
  localparam int CS_W       = ROT_FRAC_BITS + 2;
  localparam int RW         = ROT_FRAC_BITS + 4;
  localparam int PRW        = RW + CS_W;
  localparam int SUM_W      = PRW + 1;
  localparam int PP_W       = RW + CFG_W + 1;
  localparam int PW         = PP_W + 3;
  localparam int ROT_OUT_W  = 18;
  localparam int POS_OUT_W  = 22;

  typedef logic signed [ANG_W-1:0]     angle_t;
  typedef logic [CFG_W-1:0]            cfg_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic signed [CX_W-1:0]      cx_t;
  typedef logic signed [CS_W-1:0]      cs_t;
  typedef logic signed [RW-1:0]        rot_t;
  typedef logic signed [PRW-1:0]       prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [PP_W-1:0]      pp_t;
  typedef logic signed [PW-1:0]        pos_t;
  typedef logic signed [ROT_OUT_W-1:0] rot_out_t;
  typedef logic signed [POS_OUT_W-1:0] pos_out_t;

  localparam cfg_idx_t CFG_BASE_HEIGHT      = 3'd0;
  localparam cfg_idx_t CFG_UPPER_ARM_LENGTH = 3'd1;
  localparam cfg_idx_t CFG_FOREARM_LENGTH   = 3'd2;
  localparam cfg_idx_t CFG_FLANGE_LENGTH    = 3'd3;

  localparam cfg_t BASE_HEIGHT_RST      = 19'd87040;
  localparam cfg_t UPPER_ARM_LENGTH_RST = 19'd102400;
  localparam cfg_t FOREARM_LENGTH_RST   = 19'd102400;
  localparam cfg_t FLANGE_LENGTH_RST    = 19'd32256;

  localparam cx_t CORDIC_GAIN = cx_t'(64'sd652032874);
  localparam cx_t CX_QUARTER  = cx_t'(64'sd1073741824);
  localparam cx_t CX_HALF     = cx_t'(64'sd2147483648);
  localparam int  CS_SHIFT    = CORDIC_FRAC - ROT_FRAC_BITS;
  localparam cx_t CS_HALF     = cx_t'(64'sd1 <<< (CS_SHIFT - 1));
  localparam cx_t CS_LIMIT    = cx_t'(64'sd1 <<< ROT_FRAC_BITS);

  localparam rot_t ROT_ONE     = rot_t'(64'sd1 <<< ROT_FRAC_BITS);
  localparam sum_t ROT_HALF    = sum_t'(64'sd1 <<< (ROT_FRAC_BITS - 1));
  localparam pos_t POS_HALF    = pos_t'(64'sd1 <<< (ROT_FRAC_BITS - 1));
  localparam pos_t POS_LIMIT   = pos_t'(64'sd2096128);

  localparam cx_t ATAN_LUT [0:CORDIC_STEPS-1] = '{
    cx_t'(64'sd536870912), cx_t'(64'sd316933406), cx_t'(64'sd167458907),
    cx_t'(64'sd85004756),  cx_t'(64'sd42667331),  cx_t'(64'sd21354465),
    cx_t'(64'sd10679838),  cx_t'(64'sd5340245),   cx_t'(64'sd2670163),
    cx_t'(64'sd1335087),   cx_t'(64'sd667544),    cx_t'(64'sd333772),
    cx_t'(64'sd166886),    cx_t'(64'sd83443),     cx_t'(64'sd41722),
    cx_t'(64'sd20861),     cx_t'(64'sd10430),     cx_t'(64'sd5215),
    cx_t'(64'sd2608),      cx_t'(64'sd1304),      cx_t'(64'sd652),
    cx_t'(64'sd326),       cx_t'(64'sd163),       cx_t'(64'sd81),
    cx_t'(64'sd41),        cx_t'(64'sd20),        cx_t'(64'sd10),
    cx_t'(64'sd5),         cx_t'(64'sd3),         cx_t'(64'sd1)
  };

  // sine of each link twist; the first link has no twist
  localparam int TWIST_SIN [0:JOINT_COUNT-1] = '{0, -1, 1, 1, -1, -1, 1};

endpackage
`default_nettype wire

@@ src/dh_forward_kinematics_7dof.sv @@
// seven-joint modified dh forward kinematics, fully pipelined
//
//  channel | ports                               | transfer
//  --------+-------------------------------------+---------------------------
//  input   | start, busy, in_joint_angle_1..7    | start high while busy low
//  result  | out_valid, out_rot_*, out_position_* | one cycle strobe
//  config  | cfg_we, cfg_index, cfg_wdata        | cfg_we high
//
// one transfer per cycle
// 30 cordic stages run all seven angles side by side, then two stages per link
// reset holds busy high and clears every valid bit
// the receiver cannot stall, so the pipeline always advances
`default_nettype none
module dh_forward_kinematics_7dof (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  dhfk_pkg::angle_t        in_joint_angle_1,
  input  dhfk_pkg::angle_t        in_joint_angle_2,
  input  dhfk_pkg::angle_t        in_joint_angle_3,
  input  dhfk_pkg::angle_t        in_joint_angle_4,
  input  dhfk_pkg::angle_t        in_joint_angle_5,
  input  dhfk_pkg::angle_t        in_joint_angle_6,
  input  dhfk_pkg::angle_t        in_joint_angle_7,
  input  wire                     cfg_we,
  input  dhfk_pkg::cfg_idx_t      cfg_index,
  input  dhfk_pkg::cfg_t          cfg_wdata,
  output logic                    out_valid,
  output dhfk_pkg::rot_out_t      out_rot_r1c1,
  output dhfk_pkg::rot_out_t      out_rot_r1c2,
  output dhfk_pkg::rot_out_t      out_rot_r1c3,
  output dhfk_pkg::rot_out_t      out_rot_r2c1,
  output dhfk_pkg::rot_out_t      out_rot_r2c2,
  output dhfk_pkg::rot_out_t      out_rot_r2c3,
  output dhfk_pkg::rot_out_t      out_rot_r3c1,
  output dhfk_pkg::rot_out_t      out_rot_r3c2,
  output dhfk_pkg::rot_out_t      out_rot_r3c3,
  output dhfk_pkg::pos_out_t      out_position_x,
  output dhfk_pkg::pos_out_t      out_position_y,
  output dhfk_pkg::pos_out_t      out_position_z
);
  import dhfk_pkg::*;

  localparam int NJ = JOINT_COUNT;
  localparam int NS = CORDIC_STEPS;

  logic busy_r;
  cfg_t cfg_r [0:3];

  angle_t ang [0:NJ-1];
  logic   in_fire;

  // cordic pipeline
  cx_t  z0_nxt [0:NJ-1];
  logic f0_nxt [0:NJ-1];
  cx_t  cx_r [0:NS][0:NJ-1];
  cx_t  cy_r [0:NS][0:NJ-1];
  cx_t  cz_r [0:NS][0:NJ-1];
  logic cf_r [0:NS][0:NJ-1];
  logic cv_r [0:NS];

  cx_t  xo_nxt [0:NJ-1];
  cx_t  yo_nxt [0:NJ-1];
  cx_t  xr_nxt [0:NJ-1];
  cx_t  yr_nxt [0:NJ-1];
  cs_t  cos_r [0:NJ-1];
  cs_t  sin_r [0:NJ-1];
  logic sv_r;

  // link stages
  rot_t  src_rot [0:NJ-1][0:2][0:2];
  pos_t  src_pos [0:NJ-1][0:2];
  cs_t   src_c   [0:NJ-1][0:NJ-1];
  cs_t   src_s   [0:NJ-1][0:NJ-1];
  logic  src_v   [0:NJ-1];

  rot_t  la [0:NJ-1][0:2];
  rot_t  lb [0:NJ-1][0:2];
  rot_t  lsel [0:NJ-1][0:2];
  rot_t  ln2 [0:NJ-1][0:2];
  logic signed [CFG_W:0] ld [0:NJ-1];

  prod_t mac_r [0:NJ-1][0:2];
  prod_t mbs_r [0:NJ-1][0:2];
  prod_t mbc_r [0:NJ-1][0:2];
  prod_t mas_r [0:NJ-1][0:2];
  rot_t  m2_r  [0:NJ-1][0:2];
  pp_t   mpp_r [0:NJ-1][0:2];
  pos_t  mp_r  [0:NJ-1][0:2];
  cs_t   mc_r  [0:NJ-1][0:NJ-1];
  cs_t   ms_r  [0:NJ-1][0:NJ-1];
  logic  mv_r  [0:NJ-1];

  sum_t  s0_nxt [0:NJ-1][0:2];
  sum_t  s1_nxt [0:NJ-1][0:2];
  pos_t  ap_nxt [0:NJ-1][0:2];
  rot_t  ar_r [0:NJ-1][0:2][0:2];
  pos_t  ap_r [0:NJ-1][0:2];
  cs_t   ac_r [0:NJ-1][0:NJ-1];
  cs_t   as_r [0:NJ-1][0:NJ-1];
  logic  av_r [0:NJ-1];

  // output stage
  rot_t     rc_nxt [0:2][0:2];
  pos_t     pr_nxt [0:2];
  pos_t     pc_nxt [0:2];
  rot_out_t orot_r [0:2][0:2];
  pos_out_t opos_r [0:2];
  logic     out_valid_r;

  assign ang[0] = in_joint_angle_1;
  assign ang[1] = in_joint_angle_2;
  assign ang[2] = in_joint_angle_3;
  assign ang[3] = in_joint_angle_4;
  assign ang[4] = in_joint_angle_5;
  assign ang[5] = in_joint_angle_6;
  assign ang[6] = in_joint_angle_7;

  assign busy    = busy_r;
  assign in_fire = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= BASE_HEIGHT_RST;
      cfg_r[1] <= UPPER_ARM_LENGTH_RST;
      cfg_r[2] <= FOREARM_LENGTH_RST;
      cfg_r[3] <= FLANGE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_HEIGHT:      cfg_r[0] <= cfg_wdata;
        CFG_UPPER_ARM_LENGTH: cfg_r[1] <= cfg_wdata;
        CFG_FOREARM_LENGTH:   cfg_r[2] <= cfg_wdata;
        CFG_FLANGE_LENGTH:    cfg_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // fold into +-90 degrees
  always_comb begin
    for (int a = 0; a < NJ; a++) begin
      z0_nxt[a] = cx_t'(signed'({ang[a], 16'h0000}));
      f0_nxt[a] = 1'b0;
      if (z0_nxt[a] > CX_QUARTER) begin
        z0_nxt[a] = z0_nxt[a] - CX_HALF;
        f0_nxt[a] = 1'b1;
      end else if (z0_nxt[a] < -CX_QUARTER) begin
        z0_nxt[a] = z0_nxt[a] + CX_HALF;
        f0_nxt[a] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NJ; a++) begin
      cx_r[0][a] <= CORDIC_GAIN;
      cy_r[0][a] <= '0;
      cz_r[0][a] <= z0_nxt[a];
      cf_r[0][a] <= f0_nxt[a];
    end
    for (int n = 0; n < NS; n++) begin
      for (int a = 0; a < NJ; a++) begin
        cf_r[n+1][a] <= cf_r[n][a];
        if (cz_r[n][a] >= 0) begin
          cx_r[n+1][a] <= cx_r[n][a] - (cy_r[n][a] >>> n);
          cy_r[n+1][a] <= cy_r[n][a] + (cx_r[n][a] >>> n);
          cz_r[n+1][a] <= cz_r[n][a] - ATAN_LUT[n];
        end else begin
          cx_r[n+1][a] <= cx_r[n][a] + (cy_r[n][a] >>> n);
          cy_r[n+1][a] <= cy_r[n][a] - (cx_r[n][a] >>> n);
          cz_r[n+1][a] <= cz_r[n][a] + ATAN_LUT[n];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NJ; a++) begin
      xo_nxt[a] = cf_r[NS][a] ? -cx_r[NS][a] : cx_r[NS][a];
      yo_nxt[a] = cf_r[NS][a] ? -cy_r[NS][a] : cy_r[NS][a];
      xr_nxt[a] = (xo_nxt[a] + CS_HALF) >>> CS_SHIFT;
      yr_nxt[a] = (yo_nxt[a] + CS_HALF) >>> CS_SHIFT;
      if (xr_nxt[a] > CS_LIMIT) xr_nxt[a] = CS_LIMIT;
      if (xr_nxt[a] < -CS_LIMIT) xr_nxt[a] = -CS_LIMIT;
      if (yr_nxt[a] > CS_LIMIT) yr_nxt[a] = CS_LIMIT;
      if (yr_nxt[a] < -CS_LIMIT) yr_nxt[a] = -CS_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NJ; a++) begin
      cos_r[a] <= cs_t'(xr_nxt[a]);
      sin_r[a] <= cs_t'(yr_nxt[a]);
    end
  end

  // link inputs: identity pose into the first link
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        src_rot[0][i][j] = (i == j) ? ROT_ONE : '0;
      end
      src_pos[0][i] = '0;
    end
    for (int a = 0; a < NJ; a++) begin
      src_c[0][a] = cos_r[a];
      src_s[0][a] = sin_r[a];
    end
    src_v[0] = sv_r;
    for (int k = 1; k < NJ; k++) begin
      src_rot[k] = ar_r[k-1];
      src_pos[k] = ap_r[k-1];
      src_c[k]   = ac_r[k-1];
      src_s[k]   = as_r[k-1];
      src_v[k]   = av_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NJ; k++) begin
      ld[k] = ((k & 1) == 0) ? signed'({1'b0, cfg_r[k >> 1]}) : '0;
      for (int i = 0; i < 3; i++) begin
        la[k][i] = src_rot[k][i][0];
        if (k == 0) begin
          lb[k][i]   = src_rot[k][i][1];
          ln2[k][i]  = src_rot[k][i][2];
          lsel[k][i] = src_rot[k][i][2];
        end else begin
          lb[k][i]   = (TWIST_SIN[k] > 0) ? src_rot[k][i][2] : -src_rot[k][i][2];
          ln2[k][i]  = (TWIST_SIN[k] > 0) ? -src_rot[k][i][1] : src_rot[k][i][1];
          lsel[k][i] = src_rot[k][i][1];
        end
      end
    end
  end

  // link multiply stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < NJ; k++) begin
      for (int i = 0; i < 3; i++) begin
        mac_r[k][i] <= prod_t'(la[k][i]) * prod_t'(src_c[k][k]);
        mbs_r[k][i] <= prod_t'(lb[k][i]) * prod_t'(src_s[k][k]);
        mbc_r[k][i] <= prod_t'(lb[k][i]) * prod_t'(src_c[k][k]);
        mas_r[k][i] <= prod_t'(la[k][i]) * prod_t'(src_s[k][k]);
        m2_r[k][i]  <= ln2[k][i];
        mpp_r[k][i] <= pp_t'(lsel[k][i]) * pp_t'(ld[k]);
        mp_r[k][i]  <= src_pos[k][i];
      end
      mc_r[k] <= src_c[k];
      ms_r[k] <= src_s[k];
    end
  end

  always_comb begin
    for (int k = 0; k < NJ; k++) begin
      for (int i = 0; i < 3; i++) begin
        s0_nxt[k][i] = sum_t'(mac_r[k][i]) + sum_t'(mbs_r[k][i]) + ROT_HALF;
        s1_nxt[k][i] = sum_t'(mbc_r[k][i]) - sum_t'(mas_r[k][i]) + ROT_HALF;
        if (k == 0 || TWIST_SIN[k] < 0) begin
          ap_nxt[k][i] = mp_r[k][i] + pos_t'(mpp_r[k][i]);
        end else begin
          ap_nxt[k][i] = mp_r[k][i] - pos_t'(mpp_r[k][i]);
        end
      end
    end
  end

  // link accumulate stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < NJ; k++) begin
      for (int i = 0; i < 3; i++) begin
        ar_r[k][i][0] <= rot_t'(s0_nxt[k][i] >>> ROT_FRAC_BITS);
        ar_r[k][i][1] <= rot_t'(s1_nxt[k][i] >>> ROT_FRAC_BITS);
        ar_r[k][i][2] <= m2_r[k][i];
        ap_r[k][i]    <= ap_nxt[k][i];
      end
      ac_r[k] <= mc_r[k];
      as_r[k] <= ms_r[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rc_nxt[i][j] = ar_r[NJ-1][i][j];
        if (rc_nxt[i][j] > ROT_ONE) rc_nxt[i][j] = ROT_ONE;
        if (rc_nxt[i][j] < -ROT_ONE) rc_nxt[i][j] = -ROT_ONE;
      end
      pr_nxt[i] = (ap_r[NJ-1][i] + POS_HALF) >>> ROT_FRAC_BITS;
      pc_nxt[i] = pr_nxt[i];
      if (pr_nxt[i] > POS_LIMIT) pc_nxt[i] = POS_LIMIT;
      if (pr_nxt[i] < -POS_LIMIT) pc_nxt[i] = -POS_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        orot_r[i][j] <= rot_out_t'(rc_nxt[i][j]);
      end
      opos_r[i] <= pos_out_t'(pc_nxt[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n <= NS; n++) cv_r[n] <= 1'b0;
      for (int k = 0; k < NJ; k++) begin
        mv_r[k] <= 1'b0;
        av_r[k] <= 1'b0;
      end
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cv_r[0] <= in_fire;
      for (int n = 0; n < NS; n++) cv_r[n+1] <= cv_r[n];
      sv_r <= cv_r[NS];
      for (int k = 0; k < NJ; k++) begin
        mv_r[k] <= src_v[k];
        av_r[k] <= mv_r[k];
      end
      out_valid_r <= av_r[NJ-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rot_r1c1   = orot_r[0][0];
  assign out_rot_r1c2   = orot_r[0][1];
  assign out_rot_r1c3   = orot_r[0][2];
  assign out_rot_r2c1   = orot_r[1][0];
  assign out_rot_r2c2   = orot_r[1][1];
  assign out_rot_r2c3   = orot_r[1][2];
  assign out_rot_r3c1   = orot_r[2][0];
  assign out_rot_r3c2   = orot_r[2][1];
  assign out_rot_r3c3   = orot_r[2][2];
  assign out_position_x = opos_r[0];
  assign out_position_y = opos_r[1];
  assign out_position_z = opos_r[2];

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised by reset");

  a_cordic_to_links: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[NS] |=> sv_r)
    else $error("cordic result lost before the links");

  a_links_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    av_r[NJ-1] |=> out_valid)
    else $error("last link result not delivered");

  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_r1c1 <= rot_out_t'(ROT_ONE)) &&
                  (out_rot_r1c1 >= -rot_out_t'(ROT_ONE)) &&
                  (out_rot_r3c3 <= rot_out_t'(ROT_ONE)) &&
                  (out_rot_r3c3 >= -rot_out_t'(ROT_ONE)))
    else $error("rotation entry out of range");

endmodule
`default_nettype wire

@@ tb/dhfk_pose_checker.sv @@
// pose predictor and result checker for the seven-joint forward kinematics block
`timescale 1ns / 100ps
module dhfk_pose_checker
  import dhfk_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  angle_t     in_joint_angle_1,
  input  angle_t     in_joint_angle_2,
  input  angle_t     in_joint_angle_3,
  input  angle_t     in_joint_angle_4,
  input  angle_t     in_joint_angle_5,
  input  angle_t     in_joint_angle_6,
  input  angle_t     in_joint_angle_7,
  input  wire        cfg_we,
  input  cfg_idx_t   cfg_index,
  input  cfg_t       cfg_wdata,
  input  wire        out_valid,
  input  rot_out_t   out_rot_r1c1,
  input  rot_out_t   out_rot_r1c2,
  input  rot_out_t   out_rot_r1c3,
  input  rot_out_t   out_rot_r2c1,
  input  rot_out_t   out_rot_r2c2,
  input  rot_out_t   out_rot_r2c3,
  input  rot_out_t   out_rot_r3c1,
  input  rot_out_t   out_rot_r3c2,
  input  rot_out_t   out_rot_r3c3,
  input  pos_out_t   out_position_x,
  input  pos_out_t   out_position_y,
  input  pos_out_t   out_position_z,
  output int         errors,
  output int         poses_pending
);

  typedef struct packed {
    logic [8:0][ROT_OUT_W-1:0] rot;
    logic [2:0][POS_OUT_W-1:0] pos;
  } pose_t;

  localparam longint ONE = 64'sd1 <<< ROT_FRAC_BITS;

  pose_t  pose_q[$];
  longint link_offset [0:JOINT_COUNT-1];

  assign poses_pending = pose_q.size();

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void cordic_sin_cos(logic [15:0] ang, output longint c, output longint s);
    longint atan_tab [0:29];
    longint z, x, y, xs, ys;
    bit flip;
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                 10, 5, 3, 1};
    z = longint'($signed({ang, 16'h0000}));
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip((x + (64'sd1 <<< (CS_SHIFT - 1))) >>> CS_SHIFT, ONE);
    s = clip((y + (64'sd1 <<< (CS_SHIFT - 1))) >>> CS_SHIFT, ONE);
  endfunction

  function automatic pose_t end_effector_pose(logic [6:0][15:0] ang);
    longint r [0:2][0:2];
    longint nr [0:2][0:2];
    longint m [0:2][0:2];
    longint p [0:2];
    longint t [0:2];
    longint c, s, ca, sa, acc;
    pose_t res;
    r = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};
    p = '{0, 0, 0};
    for (int k = 0; k < JOINT_COUNT; k++) begin
      ca = (k == 0) ? 1 : 0;
      sa = TWIST_SIN[k];
      cordic_sin_cos(ang[k], c, s);
      m[0][0] = c;      m[0][1] = -s;     m[0][2] = 0;
      m[1][0] = s * ca; m[1][1] = c * ca; m[1][2] = -sa * ONE;
      m[2][0] = s * sa; m[2][1] = c * sa; m[2][2] = ca * ONE;
      t[0] = 0;
      t[1] = -link_offset[k] * sa;
      t[2] = link_offset[k] * ca;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i] += r[i][j] * t[j];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int n = 0; n < 3; n++) acc += r[i][n] * m[n][j];
          nr[i][j] = (acc + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
        end
      r = nr;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        res.rot[8 - (i * 3 + j)] = ROT_OUT_W'(clip(r[i][j], ONE));
    for (int i = 0; i < 3; i++)
      res.pos[2 - i] = POS_OUT_W'(clip((p[i] + (64'sd1 <<< (ROT_FRAC_BITS - 1)))
                                       >>> ROT_FRAC_BITS, 2096128));
    return res;
  endfunction

  pose_t got;

  always_comb begin
    got.rot = {out_rot_r1c1, out_rot_r1c2, out_rot_r1c3, out_rot_r2c1, out_rot_r2c2,
               out_rot_r2c3, out_rot_r3c1, out_rot_r3c2, out_rot_r3c3};
    got.pos = {out_position_x, out_position_y, out_position_z};
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      link_offset = '{longint'(BASE_HEIGHT_RST), 0, longint'(UPPER_ARM_LENGTH_RST), 0,
                      longint'(FOREARM_LENGTH_RST), 0, longint'(FLANGE_LENGTH_RST)};
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_HEIGHT:      link_offset[0] = longint'(cfg_wdata);
          CFG_UPPER_ARM_LENGTH: link_offset[2] = longint'(cfg_wdata);
          CFG_FOREARM_LENGTH:   link_offset[4] = longint'(cfg_wdata);
          CFG_FLANGE_LENGTH:    link_offset[6] = longint'(cfg_wdata);
          default: ;
        endcase
      end
      if (start && !busy)
        pose_q.push_back(end_effector_pose({in_joint_angle_7, in_joint_angle_6,
                                            in_joint_angle_5, in_joint_angle_4,
                                            in_joint_angle_3, in_joint_angle_2,
                                            in_joint_angle_1}));
      if (out_valid) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pose result at %0t", $realtime);
        end else begin
          want = pose_q.pop_front();
          for (int f = 0; f < 9; f++)
            if (got.rot[8 - f] !== want.rot[8 - f]) begin
              errors++;
              if (errors <= 10)
                $display("rot entry %0d: expected %0d got %0d", f,
                         $signed(want.rot[8 - f]), $signed(got.rot[8 - f]));
            end
          for (int f = 0; f < 3; f++)
            if (got.pos[2 - f] !== want.pos[2 - f]) begin
              errors++;
              if (errors <= 10)
                $display("position axis %0d: expected %0d got %0d", f,
                         $signed(want.pos[2 - f]), $signed(got.pos[2 - f]));
            end
        end
      end
    end
  end

endmodule

@@ tb/dh_forward_kinematics_7dof_tb.sv @@
// stimulus and verdict for the seven-joint forward kinematics block
`timescale 1ns / 100ps
module dh_forward_kinematics_7dof_tb;
  import dhfk_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  angle_t ang [0:6] = '{default: '0};
  logic cfg_we = 0;
  cfg_idx_t cfg_index = CFG_BASE_HEIGHT;
  cfg_t cfg_wdata = '0;
  wire busy, out_valid;
  rot_out_t r11, r12, r13, r21, r22, r23, r31, r32, r33;
  pos_out_t px, py, pz;
  int errors, poses_pending, quiet_cycles;
  bit no_gaps;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dh_forward_kinematics_7dof DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_joint_angle_1(ang[0]), .in_joint_angle_2(ang[1]), .in_joint_angle_3(ang[2]),
    .in_joint_angle_4(ang[3]), .in_joint_angle_5(ang[4]), .in_joint_angle_6(ang[5]),
    .in_joint_angle_7(ang[6]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_rot_r1c1(r11), .out_rot_r1c2(r12), .out_rot_r1c3(r13),
    .out_rot_r2c1(r21), .out_rot_r2c2(r22), .out_rot_r2c3(r23),
    .out_rot_r3c1(r31), .out_rot_r3c2(r32), .out_rot_r3c3(r33),
    .out_position_x(px), .out_position_y(py), .out_position_z(pz)
  );

  dhfk_pose_checker pose_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_joint_angle_1(ang[0]), .in_joint_angle_2(ang[1]), .in_joint_angle_3(ang[2]),
    .in_joint_angle_4(ang[3]), .in_joint_angle_5(ang[4]), .in_joint_angle_6(ang[5]),
    .in_joint_angle_7(ang[6]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_rot_r1c1(r11), .out_rot_r1c2(r12), .out_rot_r1c3(r13),
    .out_rot_r2c1(r21), .out_rot_r2c2(r22), .out_rot_r2c3(r23),
    .out_rot_r3c1(r31), .out_rot_r3c2(r32), .out_rot_r3c3(r33),
    .out_position_x(px), .out_position_y(py), .out_position_z(pz),
    .errors(errors), .poses_pending(poses_pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("dh_forward_kinematics_7dof_tb: done, errors");
      $finish;
    end
  end

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return angle_t'(($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) +
                         $urandom_range(0, 2) - 1);
      3: return 16'sd0;
      default: return angle_t'($urandom);
    endcase
  endfunction

  task automatic joint_transfer(input angle_t a0, a1, a2, a3, a4, a5, a6);
    int gap;
    start <= 1;
    ang[0] <= a0; ang[1] <= a1; ang[2] <= a2; ang[3] <= a3;
    ang[4] <= a4; ang[5] <= a5; ang[6] <= a6;
    do @(posedge clk); while (busy);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0:          gap = $urandom_range(10, 40);
        1, 2, 3, 4: gap = $urandom_range(1, 3);
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic uniform_transfer(input angle_t a);
    joint_transfer(a, a, a, a, a, a, a);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (poses_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_idx_t idx, input cfg_t val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_offsets(input cfg_t d1, d3, d5, d7);
    reg_write(CFG_BASE_HEIGHT, d1);
    reg_write(CFG_UPPER_ARM_LENGTH, d3);
    reg_write(CFG_FOREARM_LENGTH, d5);
    reg_write(CFG_FLANGE_LENGTH, d7);
    reg_write(cfg_idx_t'($urandom_range(4, 7)), cfg_t'($urandom));
    @(posedge clk);
  endtask

  initial begin
    no_gaps = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    uniform_transfer(16'sd0);
    uniform_transfer(-16'sd32768);
    uniform_transfer(16'sd32767);
    uniform_transfer(16'sd16384);
    uniform_transfer(-16'sd16384);
    uniform_transfer(16'sd16385);
    uniform_transfer(-16'sd16385);
    uniform_transfer(16'sd8192);
    uniform_transfer(-16'sd1);
    for (int i = 0; i < 12; i++)
      joint_transfer(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                     pick_angle(), pick_angle(), pick_angle());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_offsets('0, '0, '0, '0);
        1: set_offsets(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF);
        2: set_offsets(cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom),
                       cfg_t'($urandom));
        3: set_offsets(19'h7FFFF, '0, 19'h7FFFF, '0);
        default: set_offsets(BASE_HEIGHT_RST, UPPER_ARM_LENGTH_RST, FOREARM_LENGTH_RST,
                             FLANGE_LENGTH_RST);
      endcase
      for (int i = 0; i < 386; i++) begin
        if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        joint_transfer(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                       pick_angle(), pick_angle(), pick_angle());
      end
      no_gaps = 0;
      drain();
    end

    if (errors == 0) begin
      $display("dh_forward_kinematics_7dof_tb: done, clean");
    end else begin
      $display("dh_forward_kinematics_7dof_tb: done, errors");
    end
    $finish;
  end

endmodule
